// ===== hdl/histogram_approx_median_assert.svh =====
// Assertion macros for the histogram approximate median block.
// Included by the modules that carry assertions.
`ifndef HISTOGRAM_APPROX_MEDIAN_ASSERT_SVH
`define HISTOGRAM_APPROX_MEDIAN_ASSERT_SVH
// implication checked on every clock, off during reset
`define HAM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// same, consequence checked in the following cycle
`define HAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/ham_pkg.sv =====
// Package for the histogram approximate median block: sizes and types.
// Used by ham_div, histogram_approx_median and histogram_approx_median_checker.
package ham_pkg;
  localparam int SampleBits = 16;
  localparam int MaxSamples = 4096;
  localparam int MaxBins    = 1024;
  localparam int AddrBits   = $clog2(MaxSamples);
  localparam int CntBits    = AddrBits + 1;
  localparam int BinBits    = $clog2(MaxBins);
  localparam int BcfgBits   = 11;
  localparam int ProdBits   = SampleBits + BinBits;
  localparam logic [BcfgBits-1:0] BinCountReset = BcfgBits'(256);

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_RD, ST_MUL, ST_DIV, ST_CNT_RD, ST_INC, ST_WALK_RD, ST_WALK,
    ST_FMUL, ST_FDIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== hdl/ham_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by binning and output.
// Depends on ham_pkg.
module ham_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ham_pkg::ProdBits-1:0] dividend,
  input  logic [ham_pkg::SampleBits-1:0] divisor,
  output ham_pkg::div_ctl_t ctl,
  output logic [ham_pkg::ProdBits-1:0] quotient
);
  import ham_pkg::*;
  localparam int StepBits = $clog2(ProdBits + 1);
  logic [StepBits-1:0] step;
  logic [SampleBits:0] rem;
  logic [SampleBits:0] trial;
  logic [ProdBits-1:0] num;
  logic [SampleBits-1:0] den;
  logic busy, done;

  assign trial = {rem[SampleBits-1:0], num[ProdBits-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepBits'(ProdBits);
        rem  <= '0;
        num  <= dividend;
        den  <= divisor;
        quotient <= '0;
      end else if (busy) begin
        if (!trial[SampleBits]) begin
          rem <= trial;
        end else begin
          rem <= {rem[SampleBits-1:0], num[ProdBits-1]};
        end
        num <= {num[ProdBits-2:0], 1'b0};
        quotient <= {quotient[ProdBits-2:0], ~trial[SampleBits]};
        step <= step - 1'b1;
        if (step == StepBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ctl = '{start: start, busy: busy, done: done};

  `include "histogram_approx_median_assert.svh"
  `HAM_ASSERT_NEXT(a_done_follows, busy && step == StepBits'(1) && !start, done, "div no done")
  `HAM_ASSERT(a_not_both, done, !busy || start, "div done while busy")
  `HAM_ASSERT_NEXT(a_start_busy, start, busy, "div not busy after start")
endmodule

// ===== hdl/histogram_approx_median.sv =====
// Top level of the histogram approximate median block.
// Depends on ham_pkg, ham_div and the assertion header.
//
// Samples load one per cycle into a 4096-entry store while count, minimum and
// maximum are tracked. The item marked last closes the set; the input then
// stays not ready while a sequencer clears the bin counters in use (one per
// cycle), bins each stored sample with one multiply and a 26-step shared
// divider (read, multiply, divide, count read, increment), walks the counts
// and reconstructs the value with one more multiply and divide. A set whose
// samples are all equal skips clearing, binning and the walk and goes straight
// to the output. The result sits in an output register until taken; loading
// resumes only after it is taken.
module histogram_approx_median (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,          // bin_count in [10:0]
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [15:0] s_axis_tdata,       // sample
  input  logic s_axis_tlast,              // last
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,       // median_value[15:0], median_bin[25:16], zeros
  output logic m_axis_tuser               // all_equal
);
  import ham_pkg::*;

  logic [SampleBits-1:0] store [MaxSamples];
  logic [BinBits+2:0]    counts [MaxBins];
  logic [BcfgBits-1:0] bin_count;
  logic [CntBits-1:0] total;
  logic [SampleBits-1:0] min_v, max_v, range;
  logic [BinBits-1:0] top, bin, idx;
  logic [CntBits-1:0] cum;
  logic [CntBits-1:0] ptr;
  logic [SampleBits-1:0] rd_sample;
  logic [BinBits+2:0] rd_count;
  logic [ProdBits-1:0] prod;
  logic div_start;
  div_ctl_t dctl;
  logic [ProdBits-1:0] quot;
  state_t state, state_next;
  logic [SampleBits-1:0] res_value;
  logic [BinBits-1:0] res_bin;
  logic res_eq;
  logic accept, full;
  logic [SampleBits-1:0] new_min, new_max;
  logic [BinBits-1:0] bins_m1;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign full = total[CntBits-1];
  assign new_min = (!full && s_axis_tdata < min_v) ? s_axis_tdata : min_v;
  assign new_max = (!full && s_axis_tdata > max_v) ? s_axis_tdata : max_v;
  assign range = max_v - min_v;

  // dividend for the shared divider, taken when it starts
  assign prod = (state == ST_FMUL) ? ProdBits'(bin) * ProdBits'(range)
                                   : ProdBits'(rd_sample - min_v) * ProdBits'(top);

  always_comb begin
    if (bin_count < BcfgBits'(2)) bins_m1 = BinBits'(1);
    else if (bin_count > BcfgBits'(MaxBins)) bins_m1 = BinBits'(MaxBins - 1);
    else bins_m1 = BinBits'(bin_count - BcfgBits'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && s_axis_tlast) begin
          state_next = (new_min >= new_max) ? ST_OUT : ST_CLEAR;
        end
      end
      ST_CLEAR:   if (ptr[BinBits-1:0] == top) state_next = ST_RD;
      ST_RD:      state_next = ST_MUL;
      ST_MUL:     state_next = ST_DIV;
      ST_DIV:     if (dctl.done) state_next = ST_CNT_RD;
      ST_CNT_RD:  state_next = ST_INC;
      ST_INC:     state_next = (ptr + 1'b1 == total) ? ST_WALK_RD : ST_RD;
      ST_WALK_RD: state_next = ST_WALK;
      ST_WALK: begin
        if (cum + CntBits'(rd_count) >= (total >> 1) || bin == top) state_next = ST_FMUL;
        else state_next = ST_WALK_RD;
      end
      ST_FMUL:    state_next = ST_FDIV;
      ST_FDIV:    if (dctl.done) state_next = ST_OUT;
      ST_OUT:     if (m_axis_tready) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == ST_LOAD);
    m_axis_tvalid = (state == ST_OUT);
    div_start = (state == ST_MUL) || (state == ST_FMUL);
  end

  assign m_axis_tdata = {6'b0, res_bin, res_value};
  assign m_axis_tuser = res_eq;

  ham_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(state == ST_FMUL || state == ST_FDIV ? SampleBits'(top) : range),
    .ctl(dctl), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      bin_count <= BinCountReset;
      total <= '0;
      min_v <= '1;
      max_v <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) bin_count <= cfg_wdata[BcfgBits-1:0];
      if (state == ST_LOAD && accept) begin
        if (!full) total <= total + 1'b1;
        min_v <= new_min;
        max_v <= new_max;
      end
      if (state == ST_OUT && m_axis_tready) begin
        total <= '0;
        min_v <= '1;
        max_v <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && accept && !full) store[total[AddrBits-1:0]] <= s_axis_tdata;
    rd_sample <= store[ptr[AddrBits-1:0]];
    rd_count  <= counts[bin];
    unique case (state)
      ST_LOAD: begin
        ptr <= '0;
        top <= bins_m1;
        res_bin <= '0;
        res_eq <= 1'b1;
        res_value <= new_min;
      end
      ST_CLEAR: begin
        counts[ptr[BinBits-1:0]] <= '0;
        ptr <= (ptr[BinBits-1:0] == top) ? '0 : ptr + 1'b1;
        res_eq <= 1'b0;
      end
      ST_RD: ;
      ST_MUL: ;
      ST_DIV: begin
        if (dctl.done) begin
          idx <= (quot > ProdBits'(top)) ? top : quot[BinBits-1:0];
          bin <= (quot > ProdBits'(top)) ? top : quot[BinBits-1:0];
        end
      end
      ST_CNT_RD: ;
      ST_INC: begin
        counts[idx] <= rd_count + 1'b1;
        ptr <= ptr + 1'b1;
        if (ptr + 1'b1 == total) begin
          bin <= '0;
          cum <= '0;
        end
      end
      ST_WALK_RD: ;
      ST_WALK: begin
        cum <= cum + CntBits'(rd_count);
        if (!(cum + CntBits'(rd_count) >= (total >> 1) || bin == top)) bin <= bin + 1'b1;
      end
      ST_FMUL: res_bin <= bin;
      ST_FDIV: if (dctl.done) res_value <= min_v + quot[SampleBits-1:0];
      ST_OUT: ;
      default: ;
    endcase
  end

  `include "histogram_approx_median_assert.svh"
  `HAM_ASSERT(a_no_ready_busy, state != ST_LOAD, !s_axis_tready, "ready while busy")
  `HAM_ASSERT(a_bin_range, state == ST_OUT, res_bin <= top || res_eq, "bin above top")
  `HAM_ASSERT(a_eq_bin0, m_axis_tvalid && m_axis_tuser, res_bin == '0, "equal set bin nonzero")
  `HAM_ASSERT(a_total_cap, 1'b1, total <= CntBits'(MaxSamples), "count overflow")
endmodule

// ===== dv/histogram_approx_median_checker.sv =====
// Checker for histogram_approx_median: watches the sample and result streams,
// predicts each median from its own copy of the set and compares.
// Depends on ham_pkg for sizes.
`timescale 1ns / 1ps
module histogram_approx_median_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          pending
);
  import ham_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic [9:0]  bin;
    logic        eq;
  } median_t;

  median_t median_q[$];
  logic [15:0] set_samples[$];
  logic [15:0] set_min, set_max;
  logic [10:0] bins_reg;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic median_t compute_median();
    median_t r;
    int nbins, top, target, cum, idx;
    longint rng;
    int counts[MaxBins];
    r = '0;
    if (set_min >= set_max) begin
      r.value = set_min;
      r.eq = 1'b1;
      return r;
    end
    nbins = bins_reg;
    if (nbins < 2) nbins = 2;
    if (nbins > MaxBins) nbins = MaxBins;
    top = nbins - 1;
    rng = set_max - set_min;
    foreach (counts[i]) counts[i] = 0;
    foreach (set_samples[i]) begin
      idx = int'((longint'(set_samples[i] - set_min) * top) / rng);
      if (idx > top) idx = top;
      counts[idx]++;
    end
    target = set_samples.size() / 2;
    cum = 0;
    for (int i = 0; i < nbins; i++) begin
      cum += counts[i];
      if (cum >= target) begin
        r.bin = 10'(i);
        break;
      end
    end
    r.value = set_min + 16'((longint'(r.bin) * rng) / top);
    return r;
  endfunction

  always @(posedge clk) begin
    median_t got, want;
    if (rst) begin
      bins_reg <= BinCountReset;
      set_samples.delete();
      median_q.delete();
      set_min = '1;
      set_max = '0;
      fail_count <= 0;
      pending = 0;
    end else begin
      if (cfg_we) bins_reg <= cfg_wdata[10:0];
      if (s_axis_tvalid && s_axis_tready) begin
        // samples past store capacity are dropped
        if (set_samples.size() < MaxSamples) begin
          set_samples.insert(set_samples.size(), s_axis_tdata);
          if (s_axis_tdata < set_min) set_min = s_axis_tdata;
          if (s_axis_tdata > set_max) set_max = s_axis_tdata;
        end
        if (s_axis_tlast) begin
          median_q.insert(median_q.size(), compute_median());
          set_samples.delete();
          set_min = '1;
          set_max = '0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[15:0];
        got.bin   = m_axis_tdata[25:16];
        got.eq    = m_axis_tuser;
        if (median_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = median_q.pop_front();
          if (got.value !== want.value)
            report($sformatf("median_value %0d, want %0d", got.value, want.value));
          if (got.bin !== want.bin)
            report($sformatf("median_bin %0d, want %0d", got.bin, want.bin));
          if (got.eq !== want.eq)
            report($sformatf("all_equal %0b, want %0b", got.eq, want.eq));
          if (m_axis_tdata[31:26] !== '0) report("nonzero pad bits");
        end
      end
      pending = median_q.size();
    end
  end
endmodule

// ===== dv/histogram_approx_median_test.sv =====
// Testbench top for histogram_approx_median: drives sample sets and bin counts,
// randomizes stalls on both streams and gives the verdict.
// Depends on ham_pkg, the block and histogram_approx_median_checker.
`timescale 1ns / 1ps
module histogram_approx_median_test;
  logic        clk, rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [31:0] m_axis_tdata;
  int          fail_count, pending;
  longint      cycle_count;

  localparam longint CycleLimit = 64'd40_000_000;

  histogram_approx_median dut (.*);
  histogram_approx_median_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall per item, with stall-free stretches
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic [15:0] value, input logic is_last,
                             input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_bins(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one set; spread chooses a constant, narrow or wide value range
  task automatic send_set(input int count, input int spread, input bit no_gaps);
    logic [15:0] base, v;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < count; i++) begin
      case (spread)
        0: v = base;
        1: v = base + 16'($urandom_range(0, 7));
        default: v = 16'($urandom_range(0, 65535));
      endcase
      send_sample(v, i == count - 1, no_gaps);
    end
  endtask

  initial begin
    int items;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cycle_count = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, all-equal sets, single-sample set, two-sample set
    send_sample(16'h0000, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'h0000, 1'b1, 1'b0);
    send_sample(16'h1234, 1'b0, 1'b0);
    send_sample(16'h1234, 1'b0, 1'b0);
    send_sample(16'h1234, 1'b1, 1'b0);
    send_sample(16'h5555, 1'b0, 1'b0);
    send_sample(16'hAAAA, 1'b0, 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    write_bins(16'd0);                 // below 2 acts as 2
    send_set(6, 2, 1'b0);
    write_bins(16'd1);
    send_set(5, 1, 1'b0);
    write_bins(16'd2);
    send_set(4, 2, 1'b0);
    write_bins(16'd1024);
    send_set(5, 2, 1'b0);
    write_bins(16'hFFFF);              // above max acts as max; upper bits ignored

    items = 0;
    while (items < 720) begin
      int n, r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 4))
          0: write_bins(16'd2);
          1: write_bins(16'd1024);
          2: write_bins(16'($urandom_range(0, 2047)));
          3: write_bins(16'($urandom_range(2, 64)));
          default: write_bins(16'($urandom));
        endcase
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 2),
               $urandom_range(0, 4) == 0);
      items += n;
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/ham_pkg.sv
hdl/ham_div.sv
hdl/histogram_approx_median.sv
dv/histogram_approx_median_checker.sv
dv/histogram_approx_median_test.sv
